### rtl/firewall_rule_range_table_macros.svh
// ----------------------------------------------------------------------------
// firewall rule range table assertion macros
// shared property wrappers for the rule table checks
// ----------------------------------------------------------------------------
`ifndef FIREWALL_RULE_RANGE_TABLE_MACROS_SVH
`define FIREWALL_RULE_RANGE_TABLE_MACROS_SVH

// same-cycle implication
`define FRRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/frrt_pkg.sv
// ----------------------------------------------------------------------------
// frrt_pkg
// types and constants shared by the firewall rule range table modules
// ----------------------------------------------------------------------------
package frrt_pkg;

    localparam int RULE_SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_DEL   = 2'd1,
        FUNC_CHECK = 2'd2,
        FUNC_RSVD  = 2'd3
    } frrt_func_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_DELETED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ACCEPTED = 3'd5,
        ST_REJECTED = 3'd6
    } frrt_status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } frrt_state_t;

    // port bounds packed as high port over low port
    typedef struct packed {
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [15:0] phi;
        logic [15:0] plo;
    } frrt_rule_t;

    typedef struct packed {
        logic       valid;
        frrt_rule_t rule;
    } frrt_entry_t;

    typedef struct packed {
        frrt_func_t func;
        logic       bad;
        frrt_rule_t rule;
    } frrt_req_t;

    typedef struct packed {
        logic free;
        logic exact;
        logic hit;
    } frrt_match_t;

endpackage

### rtl/frrt_rule_mem.sv
// ----------------------------------------------------------------------------
// frrt_rule_mem
// rule storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module frrt_rule_mem #(
    parameter int SLOTS = frrt_pkg::RULE_SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  frrt_pkg::frrt_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output frrt_pkg::frrt_entry_t rd_data
);
    import frrt_pkg::*;

    frrt_entry_t store [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= store[rd_addr];
        end
    end

endmodule

### rtl/frrt_match.sv
// ----------------------------------------------------------------------------
// frrt_match
// shared compare unit, tests one stored entry against the request
// ----------------------------------------------------------------------------
module frrt_match (
    input  frrt_pkg::frrt_entry_t entry,
    input  frrt_pkg::frrt_rule_t  rule,
    output frrt_pkg::frrt_match_t result
);
    import frrt_pkg::*;

    logic addr_in;
    logic port_in;

    // on check the query is the low address and low port
    assign addr_in = (rule.alo >= entry.rule.alo) && (rule.alo <= entry.rule.ahi);
    assign port_in = (rule.plo >= entry.rule.plo) && (rule.plo <= entry.rule.phi);

    assign result.free  = !entry.valid;
    assign result.exact = entry.valid && (entry.rule == rule);
    assign result.hit   = entry.valid && addr_in && port_in;

endmodule

### rtl/frrt_seq.sv
// ----------------------------------------------------------------------------
// frrt_seq
// sequencer: clearing pass, slot walk, table update and result register
// ----------------------------------------------------------------------------
module frrt_seq #(
    parameter int SLOTS = frrt_pkg::RULE_SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    input  frrt_pkg::frrt_req_t   req,
    input  frrt_pkg::frrt_match_t match,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output frrt_pkg::frrt_entry_t wr_data
);
    import frrt_pkg::*;

    frrt_state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic         data_vld_reg, data_vld_next;
    logic [IDX_W-1:0] data_idx_reg, data_idx_next;
    frrt_status_t result_reg, result_next;
    logic         out_valid_reg, out_valid_next;
    frrt_status_t status_reg, status_next;

    logic cnt_last;
    logic data_last;
    logic found;
    logic scan_done;
    logic slot_free;

    assign cnt_last  = (cnt_reg == CNT_W'(SLOTS - 1));
    assign data_last = (data_idx_reg == IDX_W'(SLOTS - 1));
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (req.func)
            FUNC_ADD:   found = match.free;
            FUNC_DEL:   found = match.exact;
            FUNC_CHECK: found = match.hit;
            default:    found = 1'b1;
        endcase
    end

    assign scan_done = req.bad || (data_vld_reg && (found || data_last));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall       = 1'b1;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = data_idx_reg;
        wr_data.valid  = 1'b1;
        wr_data.rule   = req.rule;
        cnt_next       = cnt_reg;
        data_vld_next  = 1'b0;
        data_idx_next  = data_idx_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[IDX_W-1:0];
                wr_data  = '0;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                cnt_next = '0;
            end
            S_SCAN:
            begin
                // read slot n while slot n-1 is compared
                rd_en = (cnt_reg < CNT_W'(SLOTS));
                if (rd_en)
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    data_vld_next = 1'b1;
                    data_idx_next = cnt_reg[IDX_W-1:0];
                end
                if (req.bad)
                begin
                    result_next = ST_INVALID;
                end
                else if (data_vld_reg && found)
                begin
                    case (req.func)
                        FUNC_ADD:
                        begin
                            wr_en       = 1'b1;
                            result_next = ST_ADDED;
                        end
                        FUNC_DEL:
                        begin
                            wr_en         = 1'b1;
                            wr_data.valid = 1'b0;
                            result_next   = ST_DELETED;
                        end
                        FUNC_CHECK:
                        begin
                            result_next = ST_ACCEPTED;
                        end
                        default:
                        begin
                            result_next = ST_INVALID;
                        end
                    endcase
                end
                else if (data_vld_reg && data_last)
                begin
                    case (req.func)
                        FUNC_ADD:   result_next = ST_FULL;
                        FUNC_DEL:   result_next = ST_NOTFOUND;
                        FUNC_CHECK: result_next = ST_REJECTED;
                        default:    result_next = ST_INVALID;
                    endcase
                end
                if (scan_done)
                begin
                    data_vld_next = 1'b0;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = result_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            data_vld_reg  <= data_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= data_idx_next;
        result_reg   <= result_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

### rtl/firewall_rule_range_table.sv
// ----------------------------------------------------------------------------
// firewall_rule_range_table
// rule table of address and port ranges with add, delete and check
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid, in_stall  | func, ip_low, ip_high, ip_is_range,
//         |           |                     | port_low, port_high, port_is_range
// out     | output    | out_valid, out_stall| status
//
// a table walk reads one slot per cycle through the single read port of the
// rule memory; a match ends the walk early, and an invalid request answers
// without walking the table
// after reset a clearing pass over every slot runs with in_stall high
// one item at a time; a result waiting under out_stall holds the next answer
// ----------------------------------------------------------------------------
`include "firewall_rule_range_table_macros.svh"

module firewall_rule_range_table #(
    parameter int RULE_SLOTS = frrt_pkg::RULE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] ip_low,
    input  logic [31:0] ip_high,
    input  logic        ip_is_range,
    input  logic [15:0] port_low,
    input  logic [15:0] port_high,
    input  logic        port_is_range,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status
);
    import frrt_pkg::*;

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    frrt_req_t   req_reg, req_next;
    frrt_entry_t rd_data;
    frrt_entry_t wr_data;
    frrt_match_t match;
    logic        rd_en;
    logic        wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic        in_accept;
    logic        addr_bad;
    logic        port_bad;

    assign in_accept = in_valid && !in_stall;

    // single address or port becomes a range with equal bounds
    assign addr_bad = ip_is_range && (ip_low >= ip_high);
    assign port_bad = port_is_range && (port_high <= port_low);

    always_comb
    begin
        req_next.func     = frrt_func_t'(func);
        req_next.bad      = (frrt_func_t'(func) == FUNC_RSVD) ||
                            ((frrt_func_t'(func) != FUNC_CHECK) && (addr_bad || port_bad));
        req_next.rule.alo = ip_low;
        req_next.rule.ahi = ip_is_range ? ip_high : ip_low;
        req_next.rule.plo = port_low;
        req_next.rule.phi = port_is_range ? port_high : port_low;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= req_next;
        end
    end

    frrt_rule_mem #(
        .SLOTS (RULE_SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    frrt_match u_match (
        .entry  (rd_data),
        .rule   (req_reg.rule),
        .result (match)
    );

    frrt_seq #(
        .SLOTS (RULE_SLOTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .req       (req_reg),
        .match     (match),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    `FRRT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall, "item taken while busy")
    `FRRT_ASSERT_NOW(a_bad_gives_invalid, clk, rst_n, $rose(out_valid) && req_reg.bad, status == ST_INVALID, "invalid request not reported")
    `FRRT_ASSERT_NOW(a_check_status, clk, rst_n, $rose(out_valid) && !req_reg.bad && req_reg.func == FUNC_CHECK, status == ST_ACCEPTED || status == ST_REJECTED, "check gave a table-update status")

endmodule

### bench/rule_table_checker.sv
// ----------------------------------------------------------------------------
// rule table checker
// watches both channels, keeps its own copy of the rule table and compares
// every returned status with the answer predicted for the oldest item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rule_table_checker #(
    parameter int RULE_SLOTS = frrt_pkg::RULE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] ip_low,
    input  logic [31:0] ip_high,
    input  logic        ip_is_range,
    input  logic [15:0] port_low,
    input  logic [15:0] port_high,
    input  logic        port_is_range,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import frrt_pkg::*;

    bit           slot_used [RULE_SLOTS];
    frrt_rule_t   slot_rule [RULE_SLOTS];
    frrt_status_t answers_due [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // applies one request to the table copy and returns the status it earns
    function automatic frrt_status_t rule_table_answer(
        input frrt_func_t  op,
        input logic [31:0] a0,
        input logic [31:0] a1,
        input logic        ar,
        input logic [15:0] p0,
        input logic [15:0] p1,
        input logic        pr
    );
        frrt_rule_t r;
        logic       well_formed;
        r.alo = a0;
        r.ahi = ar ? a1 : a0;
        r.plo = p0;
        r.phi = pr ? p1 : p0;
        well_formed = !(ar && a0 >= a1) && !(pr && p1 <= p0);
        case (op)
            FUNC_ADD:
            begin
                if (!well_formed)
                    return ST_INVALID;
                for (int i = 0; i < RULE_SLOTS; i++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        slot_rule[i] = r;
                        return ST_ADDED;
                    end
                end
                return ST_FULL;
            end
            FUNC_DEL:
            begin
                if (!well_formed)
                    return ST_INVALID;
                for (int i = 0; i < RULE_SLOTS; i++)
                begin
                    if (slot_used[i] && slot_rule[i] == r)
                    begin
                        slot_used[i] = 1'b0;
                        return ST_DELETED;
                    end
                end
                return ST_NOTFOUND;
            end
            FUNC_CHECK:
            begin
                // range fields play no part in a query
                for (int i = 0; i < RULE_SLOTS; i++)
                begin
                    if (slot_used[i] && a0 >= slot_rule[i].alo && a0 <= slot_rule[i].ahi &&
                        p0 >= slot_rule[i].plo && p0 <= slot_rule[i].phi)
                        return ST_ACCEPTED;
                end
                return ST_REJECTED;
            end
            default:
                return ST_INVALID;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frrt_status_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RULE_SLOTS; i++)
                slot_used[i] = 1'b0;
            answers_due.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("status %0d with no item outstanding", status));
                else
                begin
                    want = answers_due.pop_front();
                    checked++;
                    if (status !== want)
                        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                                  status, want, want.name()));
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                answers_due.push_back(rule_table_answer(frrt_func_t'(func), ip_low, ip_high,
                                                        ip_is_range, port_low, port_high,
                                                        port_is_range));
            pending = answers_due.size();
        end
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// firewall rule range table testbench
// directed corner items, then random add, delete and check traffic in
// phases that fill and drain the table, under random sender gaps and
// receiver stalls; a separate checker predicts and compares every status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import frrt_pkg::*;

    localparam int CLK_HALF_NS  = 6;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TABLE_SLOTS  = RULE_SLOTS_DEF;
    localparam int SEGMENTS     = 6;
    localparam int SEG_ITEMS    = 80;

    typedef struct {
        frrt_func_t  func;
        logic [31:0] ip_low;
        logic [31:0] ip_high;
        logic        ip_is_range;
        logic [15:0] port_low;
        logic [15:0] port_high;
        logic        port_is_range;
    } rule_req_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] ip_low;
    logic [31:0] ip_high;
    logic        ip_is_range;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic        port_is_range;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;

    int fail_count;
    int pending;
    int checked;

    bit        hold_off_req = 1'b0;
    rule_req_t live_rules [$];
    int        func_tally [4];
    int        sent_cnt   = 0;
    int        burst_left = 1;
    int        add_pct [SEGMENTS] = '{70, 75, 10, 35, 70, 5};
    int        del_pct [SEGMENTS] = '{15, 10, 55, 30, 10, 60};

    firewall_rule_range_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .ip_low        (ip_low),
        .ip_high       (ip_high),
        .ip_is_range   (ip_is_range),
        .port_low      (port_low),
        .port_high     (port_high),
        .port_is_range (port_is_range),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status)
    );

    rule_table_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .ip_low        (ip_low),
        .ip_high       (ip_high),
        .ip_is_range   (ip_is_range),
        .port_low      (port_low),
        .port_high     (port_high),
        .port_is_range (port_is_range),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    initial clk = 1'b0;
    always #(CLK_HALF_NS) clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
        $display("timeout after %0d cycles, %0d answers outstanding", LIMIT_CYCLES, pending);
        $display("Some tests failed");
        $finish;
    end

    function automatic rule_req_t mk_req(input frrt_func_t f, input logic [31:0] a0,
                                         input logic [31:0] a1, input logic ar,
                                         input logic [15:0] p0, input logic [15:0] p1,
                                         input logic pr);
        rule_req_t r;
        r.func          = f;
        r.ip_low        = a0;
        r.ip_high       = a1;
        r.ip_is_range   = ar;
        r.port_low      = p0;
        r.port_high     = p1;
        r.port_is_range = pr;
        return r;
    endfunction

    // well-formed add, addresses clustered so that queries and deletes hit
    function automatic rule_req_t make_rule();
        rule_req_t   r;
        logic [31:0] span;
        int          cls;
        r.func = FUNC_ADD;
        cls = $urandom_range(0, 9);
        case (cls)
            0:       r.ip_low = $urandom;
            1:       r.ip_low = 32'hFFFF_FF00 | $urandom_range(0, 255);
            2:       r.ip_low = $urandom_range(0, 255);
            default: r.ip_low = 32'h0A00_0000 | $urandom_range(0, 1023);
        endcase
        r.ip_is_range = 1'($urandom_range(0, 1));
        r.ip_high     = $urandom;
        if (r.ip_is_range)
        begin
            if (r.ip_low == 32'hFFFF_FFFF)
                r.ip_low = 32'hFFFF_FFFE;
            span = (cls == 0) ? $urandom : $urandom_range(1, 40);
            if (span == 0)
                span = 1;
            r.ip_high = r.ip_low + span;
            if (r.ip_high <= r.ip_low)
                r.ip_high = 32'hFFFF_FFFF;
        end
        cls = $urandom_range(0, 9);
        case (cls)
            0:       r.port_low = 16'($urandom);
            1:       r.port_low = 16'($urandom_range(0, 15));
            2:       r.port_low = 16'hFFF0 | 16'($urandom_range(0, 15));
            default: r.port_low = 16'($urandom_range(20, 120));
        endcase
        r.port_is_range = 1'($urandom_range(0, 1));
        r.port_high     = 16'($urandom);
        if (r.port_is_range)
        begin
            if (r.port_low == 16'hFFFF)
                r.port_low = 16'hFFFE;
            span = (cls == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 10);
            r.port_high = r.port_low + 16'(span);
            if (r.port_high <= r.port_low)
                r.port_high = 16'hFFFF;
        end
        return r;
    endfunction

    // empty or reversed address range, port range, or both
    function automatic rule_req_t make_bad_rule();
        rule_req_t r;
        int        kind;
        r = make_rule();
        r.func = $urandom_range(0, 1) ? FUNC_DEL : FUNC_ADD;
        kind = $urandom_range(0, 2);
        if (kind != 1)
        begin
            r.ip_is_range = 1'b1;
            r.ip_high = r.ip_low - $urandom_range(0, 2);
            if (r.ip_high > r.ip_low)
                r.ip_high = r.ip_low;
        end
        if (kind != 0)
        begin
            r.port_is_range = 1'b1;
            r.port_high = r.port_low - 16'($urandom_range(0, 2));
            if (r.port_high > r.port_low)
                r.port_high = r.port_low;
        end
        return r;
    endfunction

    function automatic rule_req_t pick_delete();
        rule_req_t r;
        int        idx;
        int        way;
        way = $urandom_range(0, 99);
        if (live_rules.size() != 0 && way < 85)
        begin
            idx = $urandom_range(0, live_rules.size() - 1);
            r = live_rules[idx];
            r.func = FUNC_DEL;
            // unused upper bounds must not matter
            if (!r.ip_is_range)
                r.ip_high = $urandom;
            if (!r.port_is_range)
                r.port_high = 16'($urandom);
            if (way < 70)
                live_rules.delete(idx);
            else
                r.port_low = r.port_low + 16'd1;
        end
        else
        begin
            r = make_rule();
            r.func = FUNC_DEL;
        end
        return r;
    endfunction

    function automatic rule_req_t pick_query();
        rule_req_t   r;
        rule_req_t   b;
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [15:0] plo;
        logic [15:0] phi;
        logic [63:0] off;
        int          way;
        r = mk_req(FUNC_CHECK, $urandom, $urandom, 1'($urandom_range(0, 1)), 16'($urandom),
                   16'($urandom), 1'($urandom_range(0, 1)));
        way = $urandom_range(0, 99);
        if (live_rules.size() != 0 && way < 70)
        begin
            b   = live_rules[$urandom_range(0, live_rules.size() - 1)];
            alo = b.ip_low;
            ahi = b.ip_is_range ? b.ip_high : b.ip_low;
            plo = b.port_low;
            phi = b.port_is_range ? b.port_high : b.port_low;
            if (way < 50)
            begin
                off = {32'h0, $urandom} % (64'(ahi - alo) + 64'd1);
                r.ip_low   = alo + off[31:0];
                r.port_low = plo + 16'($urandom % (32'(phi - plo) + 1));
            end
            else if ($urandom_range(0, 1))
            begin
                // just past the address range
                r.ip_low   = ahi + 32'd1;
                r.port_low = plo;
            end
            else
            begin
                r.ip_low   = alo;
                r.port_low = phi + 16'd1;
            end
        end
        else
        begin
            b = make_rule();
            r.ip_low   = b.ip_low;
            r.port_low = b.port_low;
        end
        return r;
    endfunction

    function automatic rule_req_t noise_request();
        rule_req_t r;
        if ($urandom_range(0, 99) < 40)
            r = mk_req(FUNC_RSVD, $urandom, $urandom, 1'($urandom_range(0, 1)), 16'($urandom),
                       16'($urandom), 1'($urandom_range(0, 1)));
        else
            r = make_bad_rule();
        return r;
    endfunction

    task automatic send_request(input rule_req_t r);
        @(negedge clk);
        func          <= r.func;
        ip_low        <= r.ip_low;
        ip_high       <= r.ip_high;
        ip_is_range   <= r.ip_is_range;
        port_low      <= r.port_low;
        port_high     <= r.port_high;
        port_is_range <= r.port_is_range;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent_cnt++;
        func_tally[r.func]++;
    endtask

    // item followed by a gap when the current burst runs out
    task automatic offer(input rule_req_t r);
        int gap;
        send_request(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    initial
    begin : receiver
        int mode;
        int stretch;
        int hold_cnt;
        out_stall = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(16, 120);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_off_req)
                begin
                    hold_cnt = 0;
                    while (hold_cnt < 300)
                    begin
                        out_stall <= 1'b1;
                        hold_cnt++;
                        @(negedge clk);
                    end
                    hold_off_req = 1'b0;
                end
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 80);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        rule_req_t r;
        rule_req_t top_rule;
        int        pick;
        in_valid      = 1'b0;
        func          = FUNC_CHECK;
        ip_low        = '0;
        ip_high       = '0;
        ip_is_range   = 1'b0;
        port_low      = '0;
        port_high     = '0;
        port_is_range = 1'b0;
        for (int i = 0; i < 4; i++)
            func_tally[i] = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        top_rule = mk_req(FUNC_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 16'hFFFE, 16'hFFFF, 1'b1);
        // empty table, extremes, single address and single port
        offer(mk_req(FUNC_CHECK, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0));
        offer(mk_req(FUNC_ADD, 32'h0, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'hFFFF, 1'b0));
        offer(mk_req(FUNC_CHECK, 32'h0, 32'hFFFF_FFFF, 1'b1, 16'h0, 16'hFFFF, 1'b1));
        offer(top_rule);
        offer(mk_req(FUNC_CHECK, 32'hFFFF_FFFF, 32'h0, 1'b0, 16'hFFFF, 16'h0, 1'b0));
        offer(mk_req(FUNC_CHECK, 32'hFFFF_FFFD, 32'h0, 1'b0, 16'hFFFF, 16'h0, 1'b0));
        offer(mk_req(FUNC_CHECK, 32'hFFFF_FFFE, 32'h0, 1'b0, 16'hFFFD, 16'h0, 1'b0));
        // malformed ranges
        offer(mk_req(FUNC_ADD, 32'h0A00_0005, 32'h0A00_0005, 1'b1, 16'd80, 16'd0, 1'b0));
        offer(mk_req(FUNC_ADD, 32'h0A00_0006, 32'h0A00_0005, 1'b1, 16'd80, 16'd0, 1'b0));
        offer(mk_req(FUNC_ADD, 32'h0A00_0005, 32'h0, 1'b0, 16'd80, 16'd80, 1'b1));
        offer(mk_req(FUNC_ADD, 32'h0A00_0005, 32'h0, 1'b0, 16'd81, 16'd80, 1'b1));
        offer(mk_req(FUNC_DEL, 32'hFFFF_FFFF, 32'h0, 1'b1, 16'hFFFF, 16'h0, 1'b1));
        offer(mk_req(FUNC_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
        // duplicates: delete takes the lowest copy only
        offer(mk_req(FUNC_ADD, 32'h0, 32'h1234_5678, 1'b0, 16'h0, 16'h4321, 1'b0));
        offer(mk_req(FUNC_DEL, 32'h0, 32'h8765_4321, 1'b0, 16'h0, 16'h1111, 1'b0));
        offer(mk_req(FUNC_CHECK, 32'h0, 32'h5555_5555, 1'b1, 16'h0, 16'hAAAA, 1'b1));
        offer(mk_req(FUNC_DEL, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0));
        offer(mk_req(FUNC_DEL, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0));
        offer(mk_req(FUNC_DEL, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 16'hFFFD, 16'hFFFF, 1'b1));
        // whole address and port space
        offer(mk_req(FUNC_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1, 16'h0, 16'hFFFF, 1'b1));
        offer(mk_req(FUNC_CHECK, 32'h1234_5678, 32'h0, 1'b0, 16'h8000, 16'h0, 1'b0));
        offer(mk_req(FUNC_DEL, 32'h0, 32'hFFFF_FFFF, 1'b1, 16'h0, 16'hFFFF, 1'b1));
        offer(mk_req(FUNC_CHECK, 32'h1234_5678, 32'h0, 1'b0, 16'h8000, 16'h0, 1'b0));
        live_rules.push_back(top_rule);

        // phases move between filling and draining the table
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    r = noise_request();
                else if (pick < 6 + add_pct[seg])
                begin
                    r = make_rule();
                    if (live_rules.size() < TABLE_SLOTS)
                        live_rules.push_back(r);
                end
                else if (pick < 6 + add_pct[seg] + del_pct[seg])
                    r = pick_delete();
                else
                    r = pick_query();
                offer(r);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("covered %0d items: %0d adds, %0d deletes, %0d checks, %0d unused codes",
                 sent_cnt, func_tally[FUNC_ADD], func_tally[FUNC_DEL], func_tally[FUNC_CHECK],
                 func_tally[FUNC_RSVD]);
        $display("%0d statuses compared against the predicted table, %0d mismatches",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/frrt_pkg.sv
rtl/frrt_rule_mem.sv
rtl/frrt_match.sv
rtl/frrt_seq.sv
rtl/firewall_rule_range_table.sv
bench/rule_table_checker.sv
bench/tb_top.sv
